FILE: design/multi_queue_process_table_top_macros.svh
// assertion macros for the process table
`ifndef MULTI_QUEUE_PROCESS_TABLE_TOP_MACROS_SVH
`define MULTI_QUEUE_PROCESS_TABLE_TOP_MACROS_SVH
// implication checked every edge outside reset
`define MQPT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MQPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/mqpt_pkg.sv
//------------------------------------------------------------------------------
// mqpt_pkg
// shared constants and types of the multi-queue process table
//------------------------------------------------------------------------------
package mqpt_pkg;
	localparam int QueueDepth = 16;
	localparam int NumQueues = 8;
	localparam int NumSlots = NumQueues * QueueDepth;
	localparam int SlotW = $clog2(NumSlots);
	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	localparam logic [1:0] REQ_ENQ = 2'd0;
	localparam logic [1:0] REQ_DEQ = 2'd1;
	localparam logic [1:0] REQ_LOOK = 2'd2;
	localparam logic [1:0] REQ_DEL = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [2:0] Q_NEW = 3'd0;
	localparam logic [2:0] Q_RUN = 3'd7;

	typedef logic [SlotW-1:0] slot_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] psw;
		logic [31:0] page;
		logic [31:0] ra;
		logic [31:0] rb;
		logic [31:0] rc;
		logic [7:0] prio;
		logic [15:0] quanta;
		logic [2:0] grp;
	} rec_t;
endpackage

FILE: design/multi_queue_process_table_top.sv
// after the input transfer: enqueue scans one slot per cycle, then writes the record and,
// on a non-empty queue, links the old tail; dequeue reads and unlinks the head; lookup and
// delete walk one link per cycle from the tail; a request on an empty queue skips the walk.
// One request at a time, ready again the cycle after its result is registered: the slot
// scan and the link walk set the rate. A result waiting in the output register stalls only
// the next result. Asynchronous reset empties every queue; no clearing pass.
//------------------------------------------------------------------------------
// multi_queue_process_table_top
// eight doubly linked process queues, each in its own range of a shared slot memory, run by a sequencer
//------------------------------------------------------------------------------
`include "multi_queue_process_table_top_macros.svh"
module multi_queue_process_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [2:0]  queue_sel,
	input  logic [15:0] proc_id,
	input  logic [31:0] status_word,
	input  logic [31:0] page_base,
	input  logic [31:0] reg_a,
	input  logic [31:0] reg_b,
	input  logic [31:0] reg_c,
	input  logic [7:0]  prio_in,
	input  logic [15:0] quanta_in,
	input  logic [2:0]  group_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [31:0] out_status_word,
	output logic [31:0] out_page_base,
	output logic [31:0] out_reg_a,
	output logic [31:0] out_reg_b,
	output logic [31:0] out_reg_c,
	output logic [7:0]  out_prio,
	output logic [15:0] out_quanta,
	output logic [2:0]  out_group
);
	import mqpt_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_WRITE = 4'd2;
	localparam logic [3:0] S_RD = 4'd3;
	localparam logic [3:0] S_CHK = 4'd4;
	localparam logic [3:0] S_UNL = 4'd5;
	localparam logic [3:0] S_FIX = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;

	// slot pool memories, one read port each, registered read
	rec_t        rec_mem [NumSlots];
	slot_t       prev_mem [NumSlots];
	logic        hprev_mem [NumSlots];
	slot_t       next_mem [NumSlots];
	logic        hnext_mem [NumSlots];

	logic [NumSlots-1:0]  used_q;
	slot_t                head_q [NumQueues];
	slot_t                tail_q [NumQueues];
	logic [NumQueues-1:0] ne_q;

	logic [3:0]      state_q;
	logic [1:0]      req_q;
	logic [2:0]      qs_q;
	rec_t            in_q;
	slot_t           cur_q;
	logic [CntW-1:0] cnt_q;

	// read data registers
	rec_t  rrec_q;
	slot_t rprev_q;
	logic  rhprev_q;
	slot_t rnext_q;
	logic  rhnext_q;

	// fix-up of the older neighbor after unlink and of the old tail after enqueue
	logic  fix_prev_q, fix_next_q;

	logic            res_valid_q;
	logic [1:0]      res_st_q;
	rec_t            res_q;

	// output register of the result transfer
	logic [1:0]      out_st_q;
	rec_t            out_rec_q;

	logic [CntW-1:0] cap;
	slot_t           base_slot;
	slot_t           scan_slot;
	slot_t           rd_addr;
	logic            rd_en;
	logic            id_hit;

	assign cap = (qs_q == Q_NEW || qs_q == Q_RUN) ? CntW'(1) : CntW'(QueueDepth);
	assign base_slot = slot_t'({qs_q, {IdxW{1'b0}}});
	assign scan_slot = base_slot | slot_t'(cnt_q[IdxW-1:0]);
	assign id_hit = (req_q == REQ_DEQ) || (rrec_q.id == in_q.id);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = res_valid_q;
	assign status = out_st_q;
	assign out_id = out_rec_q.id;
	assign out_status_word = out_rec_q.psw;
	assign out_page_base = out_rec_q.page;
	assign out_reg_a = out_rec_q.ra;
	assign out_reg_b = out_rec_q.rb;
	assign out_reg_c = out_rec_q.rc;
	assign out_prio = out_rec_q.prio;
	assign out_quanta = out_rec_q.quanta;
	assign out_group = out_rec_q.grp;

	// read address of the shared slot port
	always_comb begin
		rd_en = 1'b0;
		rd_addr = cur_q;
		if (state_q == S_RD) begin
			rd_en = 1'b1;
		end else if (state_q == S_CHK && !id_hit && rhprev_q &&
				(cnt_q + CntW'(1) < cap)) begin
			rd_en = 1'b1;
			rd_addr = rprev_q;
		end
	end

	// memory read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rrec_q <= rec_mem[rd_addr];
			rprev_q <= prev_mem[rd_addr];
			rhprev_q <= hprev_mem[rd_addr];
			rnext_q <= next_mem[rd_addr];
			rhnext_q <= hnext_mem[rd_addr];
		end
	end

	// memory writes: record and links
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			rec_mem[cur_q] <= in_q;
			hnext_mem[cur_q] <= 1'b0;
			hprev_mem[cur_q] <= ne_q[qs_q];
			prev_mem[cur_q] <= tail_q[qs_q];
		end else if (state_q == S_UNL && rhnext_q) begin
			// newer neighbor points past the removed slot
			prev_mem[rnext_q] <= rprev_q;
			hprev_mem[rnext_q] <= rhprev_q;
		end else if (state_q == S_FIX && fix_prev_q) begin
			next_mem[rprev_q] <= rnext_q;
			hnext_mem[rprev_q] <= rhnext_q;
		end else if (state_q == S_FIX && fix_next_q) begin
			next_mem[tail_q[qs_q]] <= cur_q;
			hnext_mem[tail_q[qs_q]] <= 1'b1;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			ne_q <= '0;
			res_valid_q <= 1'b0;
			cnt_q <= '0;
			fix_prev_q <= 1'b0;
			fix_next_q <= 1'b0;
			req_q <= '0;
			qs_q <= '0;
			in_q <= '0;
			cur_q <= '0;
			res_st_q <= '0;
			res_q <= '0;
			out_st_q <= '0;
			out_rec_q <= '0;
			for (int i = 0; i < NumQueues; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (res_valid_q && out_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= req_type;
						qs_q <= queue_sel;
						in_q <= '{proc_id, status_word, page_base, reg_a, reg_b, reg_c,
							prio_in, quanta_in, group_in};
						cnt_q <= '0;
						res_q <= '0;
						priority if (req_type == REQ_ENQ) begin
							state_q <= S_SCAN;
						end else if (!ne_q[queue_sel]) begin
							res_st_q <= (req_type == REQ_LOOK) ? ST_NOTFOUND : ST_EMPTY;
							state_q <= S_DONE;
						end else begin
							cur_q <= (req_type == REQ_DEQ) ? head_q[queue_sel]
								: tail_q[queue_sel];
							state_q <= S_RD;
						end
					end
				end
				// lowest free slot of the queue's pool
				S_SCAN: begin
					if (cnt_q == cap) begin
						res_st_q <= ST_FULL;
						state_q <= S_DONE;
					end else if (!used_q[scan_slot]) begin
						cur_q <= scan_slot;
						state_q <= S_WRITE;
					end else begin
						cnt_q <= cnt_q + CntW'(1);
					end
				end
				S_WRITE: begin
					used_q[cur_q] <= 1'b1;
					if (ne_q[qs_q]) begin
						fix_next_q <= 1'b1;
						state_q <= S_FIX;
					end else begin
						head_q[qs_q] <= cur_q;
						tail_q[qs_q] <= cur_q;
						ne_q[qs_q] <= 1'b1;
						res_st_q <= ST_OK;
						state_q <= S_DONE;
					end
				end
				S_RD: state_q <= S_CHK;
				// compare one record per cycle, walking toward the head
				S_CHK: begin
					if (id_hit) begin
						res_st_q <= ST_OK;
						res_q <= rrec_q;
						if (req_q == REQ_LOOK) state_q <= S_DONE;
						else state_q <= S_UNL;
					end else if (!rhprev_q || cnt_q + CntW'(1) >= cap) begin
						res_st_q <= ST_NOTFOUND;
						state_q <= S_DONE;
					end else begin
						cur_q <= rprev_q;
						cnt_q <= cnt_q + CntW'(1);
					end
				end
				S_UNL: begin
					used_q[cur_q] <= 1'b0;
					if (!rhprev_q && !rhnext_q) ne_q[qs_q] <= 1'b0;
					if (!rhnext_q) tail_q[qs_q] <= rprev_q;
					if (!rhprev_q) head_q[qs_q] <= rnext_q;
					if (rhprev_q) begin
						fix_prev_q <= 1'b1;
						state_q <= S_FIX;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FIX: begin
					if (fix_next_q) begin
						tail_q[qs_q] <= cur_q;
						res_st_q <= ST_OK;
					end
					fix_prev_q <= 1'b0;
					fix_next_q <= 1'b0;
					state_q <= S_DONE;
				end
				// hand the result to the output register once it is free
				S_DONE: begin
					if (!res_valid_q || out_ready) begin
						res_valid_q <= 1'b1;
						out_st_q <= res_st_q;
						out_rec_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MQPT_ASSERT_IMP(a_ready_idle, in_ready, state_q == S_IDLE, "ready outside idle")
	`MQPT_ASSERT_NEXT(a_done_valid, state_q == S_DONE, out_valid, "result lost")
	`MQPT_ASSERT_IMP(a_err_zero, out_valid && status != ST_OK, out_id == 16'd0,
		"error carries record")
endmodule

FILE: dv/mqpt_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// mqpt_checker
// watches both channels of the process table, keeps its own copy of every
// queue, predicts each result and compares status and record as a whole
//------------------------------------------------------------------------------
module mqpt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [2:0]  queue_sel,
	input  logic [15:0] proc_id,
	input  logic [31:0] status_word,
	input  logic [31:0] page_base,
	input  logic [31:0] reg_a,
	input  logic [31:0] reg_b,
	input  logic [31:0] reg_c,
	input  logic [7:0]  prio_in,
	input  logic [15:0] quanta_in,
	input  logic [2:0]  group_in,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [15:0] out_id,
	input  logic [31:0] out_status_word,
	input  logic [31:0] out_page_base,
	input  logic [31:0] out_reg_a,
	input  logic [31:0] out_reg_b,
	input  logic [31:0] out_reg_c,
	input  logic [7:0]  out_prio,
	input  logic [15:0] out_quanta,
	input  logic [2:0]  out_group,
	output int          fail_count,
	output int          pending
);
	import mqpt_pkg::*;

	typedef struct packed {
		logic [1:0] st;
		rec_t       rec;
	} reply_t;

	// each queue modeled as an ordered list of (slot, record), index 0 = head
	typedef struct packed {
		logic [7:0] slot;
		rec_t       rec;
	} entry_t;

	entry_t queue_list [NumQueues][$];
	logic   slot_busy [NumSlots] = '{default: 1'b0};
	reply_t reply_q [$];
	int     mismatches = 0;

	function automatic int queue_cap(input logic [2:0] q);
		return (q == Q_NEW || q == Q_RUN) ? 1 : QueueDepth;
	endfunction

	// newest match wins: search from the tail
	function automatic int find_newest(input logic [2:0] q, input logic [15:0] id);
		for (int i = queue_list[q].size() - 1; i >= 0; i--)
			if (queue_list[q][i].rec.id == id)
				return i;
		return -1;
	endfunction

	function automatic reply_t serve_request(input logic [1:0] rt, input logic [2:0] q,
			input rec_t r);
		reply_t res;
		entry_t e;
		int k;
		int base;
		res = '0;
		base = q * QueueDepth;
		case (rt)
			REQ_ENQ: begin
				k = -1;
				for (int i = 0; i < queue_cap(q); i++)
					if (k < 0 && !slot_busy[base + i])
						k = base + i;
				if (k < 0) begin
					res.st = ST_FULL;
				end else begin
					slot_busy[k] = 1'b1;
					e.slot = k[7:0];
					e.rec = r;
					queue_list[q].push_back(e);
					res.st = ST_OK;
				end
			end
			REQ_DEQ: begin
				if (queue_list[q].size() == 0) begin
					res.st = ST_EMPTY;
				end else begin
					e = queue_list[q].pop_front();
					slot_busy[e.slot] = 1'b0;
					res.rec = e.rec;
				end
			end
			REQ_LOOK: begin
				k = find_newest(q, r.id);
				if (k < 0) res.st = ST_NOTFOUND;
				else res.rec = queue_list[q][k].rec;
			end
			default: begin
				if (queue_list[q].size() == 0) begin
					res.st = ST_EMPTY;
				end else begin
					k = find_newest(q, r.id);
					if (k < 0) begin
						res.st = ST_NOTFOUND;
					end else begin
						e = queue_list[q][k];
						queue_list[q].delete(k);
						slot_busy[e.slot] = 1'b0;
						res.rec = e.rec;
					end
				end
			end
		endcase
		return res;
	endfunction

	assign pending = reply_q.size();
	assign fail_count = mismatches;

	// predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		reply_t want;
		reply_t got;
		rec_t r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				r = '{proc_id, status_word, page_base, reg_a, reg_b, reg_c,
					prio_in, quanta_in, group_in};
				reply_q.push_back(serve_request(req_type, queue_sel, r));
			end
			if (out_valid && out_ready) begin
				got.st = status;
				got.rec = '{out_id, out_status_word, out_page_base, out_reg_a, out_reg_b,
					out_reg_c, out_prio, out_quanta, out_group};
				if (reply_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: status %0d id %h", status, out_id);
				end else begin
					want = reply_q.pop_front();
					if (want !== got) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected st %0d rec %h, got st %0d rec %h",
								want.st, want.rec, got.st, got.rec);
					end
				end
			end
		end
	end
endmodule

FILE: dv/tb_multi_queue_process_table_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_multi_queue_process_table_top
// drives directed and random queue requests under varying back-pressure and
// reports the checker's verdict
//------------------------------------------------------------------------------
module tb_multi_queue_process_table_top;
	import mqpt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [2:0]  queue_sel;
	logic [15:0] proc_id;
	logic [31:0] status_word, page_base, reg_a, reg_b, reg_c;
	logic [7:0]  prio_in;
	logic [15:0] quanta_in;
	logic [2:0]  group_in;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] out_id;
	logic [31:0] out_status_word, out_page_base, out_reg_a, out_reg_b, out_reg_c;
	logic [7:0]  out_prio;
	logic [15:0] out_quanta;
	logic [2:0]  out_group;
	int          fail_count;
	int          pending;

	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	int idle_cycles;
	logic [15:0] id_pool [8];

	multi_queue_process_table_top dut (.*);
	mqpt_checker chk (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver ready with random stalls or a long hold-off
	always @(posedge clk) begin
		if (recv_hold) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 20000 && !recv_hold) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// valid stays up after a transfer until the next item or an idle cycle replaces it
	task automatic send_item(input logic [1:0] rt, input logic [2:0] q, input logic [15:0] id,
			input bit all_ones);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		queue_sel <= q;
		proc_id <= id;
		status_word <= all_ones ? '1 : $urandom;
		page_base <= all_ones ? '1 : $urandom;
		reg_a <= all_ones ? '1 : $urandom;
		reg_b <= all_ones ? '1 : $urandom;
		reg_c <= all_ones ? '1 : $urandom;
		prio_in <= all_ones ? '1 : 8'($urandom);
		quanta_in <= all_ones ? '1 : 16'($urandom);
		group_in <= all_ones ? '1 : 3'($urandom);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// random mix: mostly ids from a small pool so lookups and deletes hit
	task automatic random_items(input int n);
		logic [1:0] rt;
		logic [2:0] q;
		logic [15:0] id;
		for (int i = 0; i < n; i++) begin
			rt = 2'($urandom_range(3));
			if ($urandom_range(9) < 4) rt = REQ_ENQ;
			q = 3'($urandom);
			id = ($urandom_range(9) < 8) ? id_pool[$urandom_range(7)] : 16'($urandom);
			send_item(rt, q, id, 1'b0);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		req_type = '0; queue_sel = '0; proc_id = '0;
		status_word = '0; page_base = '0; reg_a = '0; reg_b = '0; reg_c = '0;
		prio_in = '0; quanta_in = '0; group_in = '0;
		recv_hold = 1'b0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hffff;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empties, single-slot full, duplicates, extremes
		send_item(REQ_DEQ, 3'd1, 16'h0, 1'b0);
		send_item(REQ_LOOK, 3'd1, 16'h0, 1'b0);
		send_item(REQ_DEL, 3'd1, 16'h0, 1'b0);
		send_item(REQ_ENQ, Q_NEW, 16'hffff, 1'b1);
		send_item(REQ_ENQ, Q_NEW, 16'h0001, 1'b0);
		send_item(REQ_ENQ, Q_RUN, 16'h0000, 1'b0);
		send_item(REQ_ENQ, Q_RUN, 16'h0002, 1'b0);
		send_item(REQ_DEQ, Q_NEW, 16'h0, 1'b0);
		send_item(REQ_DEL, Q_RUN, 16'h0005, 1'b0);
		send_item(REQ_DEL, Q_RUN, 16'h0000, 1'b0);
		for (int i = 0; i < 17; i++)
			send_item(REQ_ENQ, 3'd2, (i % 3 == 0) ? 16'h00aa : 16'(i), 1'b0);
		send_item(REQ_LOOK, 3'd2, 16'h00aa, 1'b0);
		send_item(REQ_DEL, 3'd2, 16'h00aa, 1'b0);
		send_item(REQ_DEL, 3'd2, 16'h0004, 1'b0);
		send_item(REQ_ENQ, 3'd2, 16'h00bb, 1'b0);
		send_item(REQ_DEQ, 3'd2, 16'h0, 1'b0);
		send_item(REQ_LOOK, 3'd2, 16'h7777, 1'b0);
		drain();

		// long receiver hold-off while requests keep coming
		recv_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				recv_hold = 1'b0;
			end
			random_items(20);
		join
		drain();

		send_idle_pct = 29; recv_idle_pct = 49;
		random_items(170);
		drain();
		send_idle_pct = 49; recv_idle_pct = 29;
		random_items(170);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		random_items(170);
		drain();

		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule

FILE: multi_queue_process_table_top.f
+incdir+design
design/mqpt_pkg.sv
design/multi_queue_process_table_top.sv
dv/mqpt_checker.sv
dv/tb_multi_queue_process_table_top.sv
